[src/bracket_balance_checker_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bracket balance checker.
// ----------------------------------------------------------------------------
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH

// Implication checked in the same cycle.
`define BBC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bracket checker assertion failed");

// Implication checked in the next cycle.
`define BBC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bracket checker assertion failed");

`endif

[src/bbc_pkg.sv]
// ============================================================================
// bbc_pkg
// Shared types, character codes and the byte decoder of the bracket checker.
// ============================================================================
`timescale 1ns / 1ps

package bbc_pkg;

    // Characters that the checker reacts to.
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;

    // Stack entry codes.
    typedef logic [1:0] bracket_code_t;
    localparam bracket_code_t CODE_BRACE = 2'd0;
    localparam bracket_code_t CODE_BRACK = 2'd1;
    localparam bracket_code_t CODE_PAREN = 2'd2;

    // Quote kinds.
    localparam logic QUOTE_DOUBLE = 1'b0;
    localparam logic QUOTE_SINGLE = 1'b1;

    // Class of one byte.
    typedef struct packed {
        logic          is_quote;
        logic          quote_kind;
        logic          is_open;
        logic          is_close;
        bracket_code_t code;
    } char_class_t;

    // Result of one text.
    typedef struct packed {
        logic stack_overflow;
        logic valid_res;
    } bbc_result_t;

    // Classify one byte.
    function automatic char_class_t decode_char(input logic [7:0] c);
        char_class_t cls;
        cls = '0;
        unique case (c)
            CHAR_DQUOTE: begin
                cls.is_quote   = 1'b1;
                cls.quote_kind = QUOTE_DOUBLE;
            end
            CHAR_SQUOTE: begin
                cls.is_quote   = 1'b1;
                cls.quote_kind = QUOTE_SINGLE;
            end
            CHAR_LBRACE: begin
                cls.is_open = 1'b1;
                cls.code    = CODE_BRACE;
            end
            CHAR_LBRACK: begin
                cls.is_open = 1'b1;
                cls.code    = CODE_BRACK;
            end
            CHAR_LPAREN: begin
                cls.is_open = 1'b1;
                cls.code    = CODE_PAREN;
            end
            CHAR_RBRACE: begin
                cls.is_close = 1'b1;
                cls.code     = CODE_BRACE;
            end
            CHAR_RBRACK: begin
                cls.is_close = 1'b1;
                cls.code     = CODE_BRACK;
            end
            CHAR_RPAREN: begin
                cls.is_close = 1'b1;
                cls.code     = CODE_PAREN;
            end
            default: begin
                cls = '0;
            end
        endcase
        return cls;
    endfunction

endpackage

[src/bbc_stack_mem.sv]
// ============================================================================
// bbc_stack_mem
// Bracket stack storage: one write port and one registered read port.
// ============================================================================
`timescale 1ns / 1ps

module bbc_stack_mem #(
    parameter int STACK_DEPTH = 64,
    parameter int AW          = 6
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  bbc_pkg::bracket_code_t wr_data,
    input  logic [AW-1:0]         rd_addr,
    output bbc_pkg::bracket_code_t rd_data
);
    import bbc_pkg::*;

    bracket_code_t mem [STACK_DEPTH];
    bracket_code_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/bbc_core.sv]
// ============================================================================
// bbc_core
// Quote and bracket tracking with a top-of-stack register over the stack memory.
// ============================================================================
`timescale 1ns / 1ps

module bbc_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic [7:0]          character,
    input  logic                final_byte,
    input  logic                no_char,
    output logic                done,
    output bbc_pkg::bbc_result_t result
);
    import bbc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    logic [CW-1:0]  count_reg, count_next;
    logic           inside_reg, inside_next;
    logic           kind_reg, kind_next;
    logic           failed_reg, failed_next;
    logic           ovf_reg, ovf_next;
    bracket_code_t  tos_reg, tos_next;

    logic           push_we;
    bracket_code_t  below_tos;
    logic [AW-1:0]  rd_addr;
    char_class_t    cls;

    assign cls = decode_char(character);

    // The memory holds every entry; the read port always fetches the entry
    // under the top for the next state, so a pop can follow in any cycle.
    assign rd_addr = AW'(count_next - CW'(2));

    bbc_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (push_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cls.code),
        .rd_addr (rd_addr),
        .rd_data (below_tos)
    );

    // Per-item update of the stack and the string state.
    always_comb begin
        count_next  = count_reg;
        inside_next = inside_reg;
        kind_next   = kind_reg;
        failed_next = failed_reg;
        ovf_next    = ovf_reg;
        tos_next    = tos_reg;
        push_we     = 1'b0;
        done        = 1'b0;
        result      = '0;
        if (in_fire) begin
            if (!no_char && !failed_reg) begin
                if (cls.is_quote) begin
                    if (inside_reg) begin
                        if (cls.quote_kind == kind_reg) begin
                            inside_next = 1'b0;
                        end
                    end else begin
                        inside_next = 1'b1;
                        kind_next   = cls.quote_kind;
                    end
                end else if (!inside_reg) begin
                    if (cls.is_open) begin
                        if (count_reg == DEPTH_C) begin
                            ovf_next    = 1'b1;
                            failed_next = 1'b1;
                        end else begin
                            push_we    = 1'b1;
                            tos_next   = cls.code;
                            count_next = count_reg + CW'(1);
                        end
                    end else if (cls.is_close) begin
                        if (count_reg == '0 || tos_reg != cls.code) begin
                            failed_next = 1'b1;
                        end else begin
                            count_next = count_reg - CW'(1);
                            tos_next   = below_tos;
                        end
                    end
                end
            end
            // End of text: report and return to the cleared state.
            if (final_byte) begin
                done                  = 1'b1;
                result.valid_res      = !failed_next && !ovf_next && !inside_next &&
                                        (count_next == '0);
                result.stack_overflow = ovf_next;
                count_next            = '0;
                inside_next           = 1'b0;
                kind_next             = QUOTE_DOUBLE;
                failed_next           = 1'b0;
                ovf_next              = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            inside_reg <= 1'b0;
            kind_reg   <= QUOTE_DOUBLE;
            failed_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end else begin
            count_reg  <= count_next;
            inside_reg <= inside_next;
            kind_reg   <= kind_next;
            failed_reg <= failed_next;
            ovf_reg    <= ovf_next;
        end
    end

    // Top-of-stack register; only read while the stack is not empty.
    always_ff @(posedge aclk) begin
        tos_reg <= tos_next;
    end

endmodule

[src/bracket_balance_checker_top.sv]
// ----------------------------------------------------------------------------
// Bracket balance checker: one byte of a text per input item. Outside quoted
// strings, opening braces, brackets and parentheses are stacked and each
// closer must match the top. s_axis_tlast marks the last item of a text and
// s_axis_tuser marks an item that carries no byte, so an empty text works.
// One result item follows each last input item, in the cycle after it is
// accepted, from an output register. Throughput is one item per cycle: the
// top of the stack sits in a register and the memory read port always holds
// the entry below it, so pushes and pops may follow in consecutive cycles.
// While a result waits, non-last items are still accepted; a last item is
// held off only until the waiting result is taken. A text nested deeper
// than STACK_DEPTH is reported invalid with the overflow bit set.
// Reset clears the control state at once; the stack memory needs no
// clearing pass, as only entries written in the current text are read.
// After each result the block is ready for the next text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_balance_checker_top #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] character
    input  logic       s_axis_tlast,   // final_byte
    input  logic       s_axis_tuser,   // no_char
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] valid_res, [1] stack_overflow, [7:2] zero
);
    import bbc_pkg::*;

    logic        in_fire;
    logic        done;
    bbc_result_t result;
    logic        m_valid_reg, m_valid_next;
    bbc_result_t res_reg;

    // A last item needs a free output register; other items always pass.
    assign s_axis_tready = !m_valid_reg || m_axis_tready || !s_axis_tlast;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    bbc_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .character  (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .no_char    (s_axis_tuser),
        .done       (done),
        .result     (result)
    );

    // Output register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (done) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (done) begin
            res_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, res_reg.stack_overflow, res_reg.valid_res};

endmodule

[src/bbc_checker.sv]
// ============================================================================
// bbc_checker
// Port-level checks of the bracket balance checker, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "bracket_balance_checker_top_assert.svh"

module bbc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A stalled result holds its value.
    `BBC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // A text cannot be valid and overflowed at once; padding stays zero.
    `BBC_ASSERT_NOW(a_out_coding, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]) && (m_axis_tdata[7:2] == 6'd0))

    // A new result appears only after a last item was accepted.
    `BBC_ASSERT_NOW(a_out_cause, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))

    // A last item is held off while a result is stalled.
    `BBC_ASSERT_NOW(a_last_backpressure, s_axis_tlast && m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/tb_bracket_balance_checker_top.sv]
// ============================================================================
// Testbench for bracket_balance_checker_top
// Sends texts one byte per item: a short directed set of texts, then random
// balanced, broken, noisy and deeply nested texts. A scoreboard class keeps
// its own model of the bracket stack and quote state and compares every
// result item with the verdict it predicts. Both stream sides idle in bursts,
// and once the result side holds off long enough to stall the input side.
// ============================================================================
`timescale 1ns / 1ps

module tb_bracket_balance_checker_top;
    import bbc_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int ITEM_TARGET = 1400;
    localparam int CALM_AFTER  = 1200;
    localparam int LONG_HOLD   = 400;

    // One input item of a text.
    typedef struct {
        logic [7:0] ch;
        logic       is_last;
        logic       no_char;
    } text_item_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks nesting and quote state, queues the expected verdicts.
    // ------------------------------------------------------------------------
    class bracket_scoreboard;
        bracket_code_t nest_stack[STACK_DEPTH];
        int unsigned   depth;
        bit            quote_open;
        logic          string_kind;
        bit            failed;
        bit            overflowed;
        bbc_result_t   verdicts_due[$];
        int unsigned   error_count;

        function new();
            error_count = 0;
            clear_text();
        endfunction

        function void clear_text();
            depth       = 0;
            quote_open  = 0;
            string_kind = QUOTE_DOUBLE;
            failed      = 0;
            overflowed  = 0;
        endfunction

        function void push_bracket(bracket_code_t code);
            if (depth >= STACK_DEPTH) begin
                overflowed = 1;
                failed     = 1;
            end else begin
                nest_stack[depth] = code;
                depth++;
            end
        endfunction

        function void pop_bracket(bracket_code_t code);
            if (depth == 0 || nest_stack[depth - 1] != code) begin
                failed = 1;
            end else begin
                depth--;
            end
        endfunction

        // Apply one byte of the text to the model state.
        function void consume_char(logic [7:0] c);
            logic kind;
            if (failed) return;
            if (c == CHAR_DQUOTE || c == CHAR_SQUOTE) begin
                kind = (c == CHAR_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
                if (!quote_open) begin
                    quote_open  = 1;
                    string_kind = kind;
                end else if (kind == string_kind) begin
                    quote_open = 0;
                end
                return;
            end
            if (quote_open) return;
            case (c)
                CHAR_LBRACE: push_bracket(CODE_BRACE);
                CHAR_LBRACK: push_bracket(CODE_BRACK);
                CHAR_LPAREN: push_bracket(CODE_PAREN);
                CHAR_RBRACE: pop_bracket(CODE_BRACE);
                CHAR_RBRACK: pop_bracket(CODE_BRACK);
                CHAR_RPAREN: pop_bracket(CODE_PAREN);
                default: ;
            endcase
        endfunction

        // Record an accepted input item; the last item of a text yields a verdict.
        function void note_input(logic [7:0] c, logic is_last, logic no_char);
            bbc_result_t verdict;
            if (!no_char) consume_char(c);
            if (is_last) begin
                verdict.valid_res      = !failed && !overflowed && !quote_open && depth == 0;
                verdict.stack_overflow = overflowed;
                verdicts_due.push_back(verdict);
                clear_text();
            end
        endfunction

        // Compare one accepted result item with the oldest expected verdict.
        function void check_result(logic [7:0] data);
            bbc_result_t verdict;
            if (verdicts_due.size() == 0) begin
                $error("result item 0x%02h arrived with no text pending", data);
                error_count++;
                return;
            end
            verdict = verdicts_due.pop_front();
            if (data[0] !== verdict.valid_res) begin
                $error("valid_res: expected %0b, actual %0b", verdict.valid_res, data[0]);
                error_count++;
            end
            if (data[1] !== verdict.stack_overflow) begin
                $error("stack_overflow: expected %0b, actual %0b",
                       verdict.stack_overflow, data[1]);
                error_count++;
            end
            if (data[7:2] !== 6'd0) begin
                $error("tdata padding: expected 0, actual %0h", data[7:2]);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return verdicts_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports.
    // ------------------------------------------------------------------------
    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'd0;
    logic       s_axis_tlast  = 1'b0;
    logic       s_axis_tuser  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    bracket_scoreboard sb = new();
    text_item_t        text_q[$];
    int unsigned       items_sent   = 0;
    bit                idle_on      = 1;
    bit                hold_request = 0;

    always #6 aclk = ~aclk;

    bracket_balance_checker_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // [7:0] character
        .s_axis_tlast (s_axis_tlast),   // final_byte
        .s_axis_tuser (s_axis_tuser),   // no_char
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)    // [0] valid_res, [1] stack_overflow, [7:2] zero
    );

    // ------------------------------------------------------------------------
    // Text building helpers.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] opener_of(bracket_code_t code);
        case (code)
            CODE_BRACE: return CHAR_LBRACE;
            CODE_BRACK: return CHAR_LBRACK;
            default:    return CHAR_LPAREN;
        endcase
    endfunction

    function automatic logic [7:0] closer_of(bracket_code_t code);
        case (code)
            CODE_BRACE: return CHAR_RBRACE;
            CODE_BRACK: return CHAR_RBRACK;
            default:    return CHAR_RPAREN;
        endcase
    endfunction

    function automatic bracket_code_t random_code();
        case ($urandom_range(0, 2))
            0:       return CODE_BRACE;
            1:       return CODE_BRACK;
            default: return CODE_PAREN;
        endcase
    endfunction

    function automatic logic [7:0] special_byte();
        case ($urandom_range(0, 7))
            0:       return CHAR_DQUOTE;
            1:       return CHAR_SQUOTE;
            2:       return CHAR_LBRACE;
            3:       return CHAR_LBRACK;
            4:       return CHAR_LPAREN;
            5:       return CHAR_RBRACE;
            6:       return CHAR_RBRACK;
            default: return CHAR_RPAREN;
        endcase
    endfunction

    // Any byte the checker does not react to.
    function automatic logic [7:0] filler_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CHAR_DQUOTE || c == CHAR_SQUOTE || c == CHAR_LBRACE ||
               c == CHAR_LBRACK || c == CHAR_LPAREN || c == CHAR_RBRACE ||
               c == CHAR_RBRACK || c == CHAR_RPAREN)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Append a byte; now and then an empty item with a random byte goes first.
    function automatic void add_byte(logic [7:0] c);
        if ($urandom_range(0, 19) == 0)
            text_q.push_back('{ch: 8'($urandom_range(0, 255)), is_last: 1'b0, no_char: 1'b1});
        text_q.push_back('{ch: c, is_last: 1'b0, no_char: 1'b0});
    endfunction

    // Well-formed text with random content, nesting at most depth_cap.
    function automatic void build_balanced(int len, int depth_cap);
        bracket_code_t open_q[$];
        bracket_code_t code;
        logic [7:0]    q;
        logic [7:0]    c;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    if (open_q.size() < depth_cap) begin
                        code = random_code();
                        open_q.push_back(code);
                        add_byte(opener_of(code));
                    end else begin
                        add_byte(filler_byte());
                    end
                end
                3, 4, 5: begin
                    if (open_q.size() > 0) add_byte(closer_of(open_q.pop_back()));
                    else add_byte(filler_byte());
                end
                6: begin
                    // Quoted string holding anything but its own quote.
                    q = $urandom_range(0, 1) ? CHAR_SQUOTE : CHAR_DQUOTE;
                    add_byte(q);
                    repeat ($urandom_range(0, 4)) begin
                        c = $urandom_range(0, 1) ? special_byte() : 8'($urandom_range(0, 255));
                        if (c == q) c = filler_byte();
                        add_byte(c);
                    end
                    add_byte(q);
                end
                default: add_byte(filler_byte());
            endcase
        end
        while (open_q.size() > 0) add_byte(closer_of(open_q.pop_back()));
    endfunction

    // Nest nest_depth openers, then close them in order.
    function automatic void build_deep(int nest_depth);
        bracket_code_t open_q[$];
        bracket_code_t code;
        for (int i = 0; i < nest_depth; i++) begin
            code = random_code();
            open_q.push_back(code);
            add_byte(opener_of(code));
        end
        while (open_q.size() > 0) add_byte(closer_of(open_q.pop_back()));
    endfunction

    // ------------------------------------------------------------------------
    // Stream drivers.
    // ------------------------------------------------------------------------
    task automatic send_item(input text_item_t it);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.ch;
        s_axis_tlast  <= it.is_last;
        s_axis_tuser  <= it.no_char;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_input(it.ch, it.is_last, it.no_char);
        items_sent++;
    endtask

    // Mark the end of the built text and send it; sometimes end on an empty item.
    task automatic send_text();
        if (text_q.size() == 0 || $urandom_range(0, 7) == 0)
            text_q.push_back('{ch: 8'($urandom_range(0, 255)), is_last: 1'b0, no_char: 1'b1});
        text_q[text_q.size() - 1].is_last = 1'b1;
        foreach (text_q[i]) send_item(text_q[i]);
        text_q.delete();
    endtask

    task automatic send_chars(input string s, input logic end_empty);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back('{ch: s[i], is_last: 1'b0, no_char: 1'b0});
        if (end_empty)
            text_q.push_back('{ch: CHAR_LPAREN, is_last: 1'b0, no_char: 1'b1});
        text_q[text_q.size() - 1].is_last = 1'b1;
        foreach (text_q[i]) send_item(text_q[i]);
        text_q.delete();
    endtask

    // ------------------------------------------------------------------------
    // Result side: random backpressure, one long hold on request.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (hold_request) begin
                hold_request = 0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned text_count;
        int unsigned pick;
        int unsigned spot;
        text_count = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed texts: empty text, simple pairs, mismatch, closer on an
        // empty stack, quotes hiding brackets, unclosed quote, open bracket,
        // and the byte extremes.
        send_chars("", 1'b1);
        send_chars("()", 1'b0);
        send_chars("{[()]}", 1'b1);
        send_chars("(])", 1'b0);
        send_chars(")", 1'b0);
        send_chars("\"'(\"", 1'b0);
        text_q.push_back('{ch: CHAR_SQUOTE, is_last: 1'b0, no_char: 1'b0});
        text_q.push_back('{ch: 8'h00, is_last: 1'b1, no_char: 1'b0});
        foreach (text_q[i]) send_item(text_q[i]);
        text_q.delete();
        text_q.push_back('{ch: 8'hFF, is_last: 1'b0, no_char: 1'b0});
        text_q.push_back('{ch: CHAR_LBRACK, is_last: 1'b1, no_char: 1'b0});
        foreach (text_q[i]) send_item(text_q[i]);
        text_q.delete();

        // Random texts, mostly well formed.
        while (items_sent < ITEM_TARGET) begin
            if (text_count == 12) hold_request = 1;
            if (items_sent > CALM_AFTER) idle_on = 0;
            pick = $urandom_range(0, 99);
            if (text_count == 3) begin
                build_deep(STACK_DEPTH + 1);
            end else if (text_count == 20) begin
                build_deep(STACK_DEPTH);
            end else if (pick < 2) begin
                build_deep(STACK_DEPTH - 2 + $urandom_range(0, 8));
            end else if (pick < 65) begin
                build_balanced($urandom_range(1, 24), $urandom_range(1, 8));
            end else if (pick < 85) begin
                // Broken text: one byte replaced by a special one, or cut short.
                build_balanced($urandom_range(2, 24), $urandom_range(1, 8));
                if ($urandom_range(0, 2) != 0) begin
                    spot = $urandom_range(0, text_q.size() - 1);
                    text_q[spot].ch      = special_byte();
                    text_q[spot].no_char = 1'b0;
                end else begin
                    repeat ($urandom_range(1, 3))
                        if (text_q.size() > 1) void'(text_q.pop_back());
                end
            end else begin
                // Noise, rich in special bytes.
                repeat ($urandom_range(1, 12))
                    add_byte($urandom_range(0, 1) ? special_byte() : 8'($urandom_range(0, 255)));
            end
            send_text();
            text_count++;
        end
        s_axis_tvalid <= 1'b0;

        // Drain the remaining verdicts, then let the block settle.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.error_count == 0) begin
            $display("bracket_balance_checker_top regression: pass");
        end else begin
            $display("bracket_balance_checker_top regression: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #5_000_000;
        $display("bracket_balance_checker_top regression: fail");
        $finish;
    end

endmodule
